/* src/psm_pkg.sv */
// Shared types and constants for the power-sum / top-k statistics block.
// No dependencies; imported by every module under src/.
`default_nettype none
package psm_pkg;

   localparam int unsigned TOP_COUNT_DEF = 201;

   localparam int unsigned VAL_W   = 16;
   localparam int unsigned MAG_W   = 16;
   localparam int unsigned RANK_W  = 8;
   localparam int unsigned SIZE_W  = 8;
   localparam int unsigned CNT_W   = 32;
   localparam int unsigned SUM1_W  = 48;
   localparam int unsigned SUM_W   = 64;
   localparam int unsigned SQ_W    = 32;
   localparam int unsigned CUBE_W  = 46;
   localparam int unsigned QUAD_W  = 61;

   typedef enum logic [1:0] {
      FUNC_ADD   = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_CLEAR = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic insert;
      logic clear;
   } list_cmd_type;

endpackage
`default_nettype wire

/* src/power_sum_moments_with_top_k_core.sv */
// Running power sums (x .. x^4), nonzero count, peak magnitude and a sorted
// top-k magnitude list over a stream of signed 16-bit samples.
// Depends on psm_pkg, psm_power and psm_topk.
//
// Usage:
//  - req_* carries one request: req_func selects add sample (0), read the
//    list entry at req_rank (1) or clear all statistics (2); code 3 only
//    reports. Every request produces exactly one response on rsp_*.
//  - A request is taken when req_valid and req_ready are high; req_ready is
//    high while the block is idle. The response carries the statistics after
//    the request took effect.
//  - An accepted request passes the SQUARE and UPDATE states; its result is
//    committed in UPDATE once the output register is free. A new request can
//    be taken the cycle after a result is committed, so one request is in
//    flight at a time in the two-stage multiply pipeline (square, then cube
//    and fourth power) feeding the saturating accumulators.
//  - The top-k list is a chain of TOP_COUNT cells; an insert shifts the
//    whole chain in parallel and a rank read is a registered mux.
//  - If rsp_ready is low, the finished result waits in the output register
//    and the next request's commit stalls until that response is taken.
//  - Synchronous reset clears all statistics and empties the list directly;
//    there is no clearing pass.
`default_nettype none
module power_sum_moments_with_top_k_core #(
   parameter int unsigned TOP_COUNT = psm_pkg::TOP_COUNT_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [1:0]                         req_func,
   input  wire logic signed [psm_pkg::VAL_W-1:0]   req_value,
   input  wire logic [psm_pkg::RANK_W-1:0]         req_rank,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [psm_pkg::CNT_W-1:0]               rsp_nonzero_count,
   output logic signed [psm_pkg::SUM1_W-1:0]       rsp_sum_first,
   output logic [psm_pkg::SUM_W-1:0]               rsp_sum_second,
   output logic signed [psm_pkg::SUM_W-1:0]        rsp_sum_third,
   output logic [psm_pkg::SUM_W-1:0]               rsp_sum_fourth,
   output logic [psm_pkg::MAG_W-1:0]               rsp_max_magnitude,
   output logic [psm_pkg::MAG_W-1:0]               rsp_ranked_magnitude,
   output logic                                    rsp_rank_valid,
   output logic [psm_pkg::SIZE_W-1:0]              rsp_list_size,
   output logic                                    rsp_saturated
);
   import psm_pkg::*;

   state_type state_ff, state_in;
   logic      accept, commit;

   func_type          func_ff;
   logic [VAL_W-1:0]  value_ff;
   logic [RANK_W-1:0] rank_ff;

   logic [MAG_W-1:0]  mag;
   logic [SQ_W-1:0]   sq;
   logic [CUBE_W-1:0] cube;
   logic [QUAD_W-1:0] quad;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SUM1_W-1:0] sum1_ff, sum1_in;
   logic [SUM_W-1:0]  sum2_ff, sum2_in;
   logic [SUM_W-1:0]  sum3_ff, sum3_in;
   logic [SUM_W-1:0]  sum4_ff, sum4_in;
   logic [MAG_W-1:0]  peak_ff, peak_in;
   logic              sat_ff, sat_in;

   logic [SUM1_W:0]   s1;
   logic [SUM_W:0]    s2, s3, s4, cube_ext, cube_s;
   logic              nz, sat_hit;
   logic [CNT_W-1:0]  count_add;
   logic [SUM1_W-1:0] sum1_add;
   logic [SUM_W-1:0]  sum2_add, sum3_add, sum4_add;
   logic              ovf1, ovf2, ovf3, ovf4, ovfc;

   list_cmd_type      list_cmd;
   logic [MAG_W-1:0]  rd_mag;
   logic              rd_valid;
   logic [SIZE_W-1:0] size_next;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]  o_count_ff;
   logic [SUM1_W-1:0] o_sum1_ff;
   logic [SUM_W-1:0]  o_sum2_ff, o_sum3_ff, o_sum4_ff;
   logic [MAG_W-1:0]  o_peak_ff, o_rmag_ff;
   logic              o_rvalid_ff, o_sat_ff;
   logic [SIZE_W-1:0] o_size_ff;

   // ---- control ----
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_UPDATE;
         ST_UPDATE: if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      commit    = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SQUARE: ;
         ST_UPDATE: commit = !rsp_valid_ff || rsp_ready;
         default:   ;
      endcase
   end

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= func_type'(req_func);
         value_ff <= req_value;
         rank_ff  <= req_rank;
      end
   end

   psm_power u_power (
      .clock (clock),
      .load  (accept),
      .value (req_value),
      .mag   (mag),
      .sq    (sq),
      .cube  (cube),
      .quad  (quad)
   );

   // ---- saturating accumulation ----
   assign nz = mag != '0;

   assign ovfc      = nz && (count_ff == '1);
   assign count_add = (nz && !ovfc) ? count_ff + CNT_W'(1) : count_ff;

   assign s1       = {sum1_ff[SUM1_W-1], sum1_ff}
                   + {{(SUM1_W+1-VAL_W){value_ff[VAL_W-1]}}, value_ff};
   assign ovf1     = s1[SUM1_W] != s1[SUM1_W-1];
   assign sum1_add = ovf1 ? {s1[SUM1_W], {(SUM1_W-1){~s1[SUM1_W]}}}
                          : s1[SUM1_W-1:0];

   assign s2       = {1'b0, sum2_ff} + (SUM_W+1)'(sq);
   assign ovf2     = s2[SUM_W];
   assign sum2_add = ovf2 ? '1 : s2[SUM_W-1:0];

   assign cube_ext = (SUM_W+1)'(cube);
   assign cube_s   = value_ff[VAL_W-1] ? (~cube_ext + (SUM_W+1)'(1)) : cube_ext;
   assign s3       = {sum3_ff[SUM_W-1], sum3_ff} + cube_s;
   assign ovf3     = s3[SUM_W] != s3[SUM_W-1];
   assign sum3_add = ovf3 ? {s3[SUM_W], {(SUM_W-1){~s3[SUM_W]}}}
                          : s3[SUM_W-1:0];

   assign s4       = {1'b0, sum4_ff} + (SUM_W+1)'(quad);
   assign ovf4     = s4[SUM_W];
   assign sum4_add = ovf4 ? '1 : s4[SUM_W-1:0];

   assign sat_hit = ovfc || ovf1 || ovf2 || ovf3 || ovf4;

   always_comb begin
      count_in = count_ff;
      sum1_in  = sum1_ff;
      sum2_in  = sum2_ff;
      sum3_in  = sum3_ff;
      sum4_in  = sum4_ff;
      peak_in  = peak_ff;
      sat_in   = sat_ff;
      unique case (func_ff)
         FUNC_ADD: begin
            count_in = count_add;
            sum1_in  = sum1_add;
            sum2_in  = sum2_add;
            sum3_in  = sum3_add;
            sum4_in  = sum4_add;
            peak_in  = (mag > peak_ff) ? mag : peak_ff;
            sat_in   = sat_ff || sat_hit;
         end
         FUNC_CLEAR: begin
            count_in = '0;
            sum1_in  = '0;
            sum2_in  = '0;
            sum3_in  = '0;
            sum4_in  = '0;
            peak_in  = '0;
            sat_in   = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum1_ff  <= '0;
         sum2_ff  <= '0;
         sum3_ff  <= '0;
         sum4_ff  <= '0;
         peak_ff  <= '0;
         sat_ff   <= 1'b0;
      end else if (commit) begin
         count_ff <= count_in;
         sum1_ff  <= sum1_in;
         sum2_ff  <= sum2_in;
         sum3_ff  <= sum3_in;
         sum4_ff  <= sum4_in;
         peak_ff  <= peak_in;
         sat_ff   <= sat_in;
      end
   end

   // ---- top-k list ----
   assign list_cmd.insert = commit && (func_ff == FUNC_ADD) && nz;
   assign list_cmd.clear  = commit && (func_ff == FUNC_CLEAR);

   psm_topk #(
      .TOP_COUNT (TOP_COUNT)
   ) u_topk (
      .clock     (clock),
      .reset     (reset),
      .cmd       (list_cmd),
      .mag       (mag),
      .rank      (rank_ff),
      .rd_mag    (rd_mag),
      .rd_valid  (rd_valid),
      .size_next (size_next)
   );

   // ---- output register ----
   assign rsp_valid_in = commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         o_count_ff  <= count_in;
         o_sum1_ff   <= sum1_in;
         o_sum2_ff   <= sum2_in;
         o_sum3_ff   <= sum3_in;
         o_sum4_ff   <= sum4_in;
         o_peak_ff   <= peak_in;
         o_rmag_ff   <= (func_ff == FUNC_READ) ? rd_mag : '0;
         o_rvalid_ff <= (func_ff == FUNC_READ) && rd_valid;
         o_size_ff   <= size_next;
         o_sat_ff    <= sat_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_nonzero_count    = o_count_ff;
   assign rsp_sum_first        = o_sum1_ff;
   assign rsp_sum_second       = o_sum2_ff;
   assign rsp_sum_third        = o_sum3_ff;
   assign rsp_sum_fourth       = o_sum4_ff;
   assign rsp_max_magnitude    = o_peak_ff;
   assign rsp_ranked_magnitude = o_rmag_ff;
   assign rsp_rank_valid       = o_rvalid_ff;
   assign rsp_list_size        = o_size_ff;
   assign rsp_saturated        = o_sat_ff;

   chk_rsp_from_update : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("response raised outside update");

   chk_sat_sticky : assert property (@(posedge clock) disable iff (reset)
      $fell(sat_ff) |-> ($past(reset) || $past(commit && func_ff == FUNC_CLEAR)))
      else $error("saturated flag dropped without clear");

   chk_peak_monotonic : assert property (@(posedge clock) disable iff (reset)
      (commit && func_ff != FUNC_CLEAR) |=> peak_ff >= $past(peak_ff))
      else $error("peak magnitude decreased");
endmodule
`default_nettype wire

/* src/psm_cell.sv */
// One cell of the sorted magnitude chain: holds one entry and its valid bit.
// Depends on psm_pkg.
`default_nettype none
module psm_cell (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire psm_pkg::list_cmd_type      cmd,
   input  wire logic [psm_pkg::MAG_W-1:0]  mag,
   input  wire logic                       left_ge,
   input  wire logic                       left_valid,
   input  wire logic [psm_pkg::MAG_W-1:0]  left_val,
   output logic [psm_pkg::MAG_W-1:0]       val,
   output logic                            valid,
   output logic                            ge
);
   import psm_pkg::*;

   logic [MAG_W-1:0] val_ff, val_in;
   logic             valid_ff, valid_in;

   // entry stays put when it is strictly larger than the new magnitude
   always_comb ge = valid_ff && (val_ff > mag);

   always_comb begin
      val_in   = val_ff;
      valid_in = valid_ff;
      if (cmd.clear) begin
         valid_in = 1'b0;
      end else if (cmd.insert && !ge) begin
         val_in   = left_ge ? mag : left_val;
         valid_in = left_valid;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign val   = val_ff;
   assign valid = valid_ff;
endmodule
`default_nettype wire

/* src/psm_topk.sv */
// Top-k list: a chain of psm_cell, the fill counter and the rank read mux.
// Depends on psm_pkg and psm_cell.
`default_nettype none
module psm_topk #(
   parameter int unsigned TOP_COUNT = psm_pkg::TOP_COUNT_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire psm_pkg::list_cmd_type       cmd,
   input  wire logic [psm_pkg::MAG_W-1:0]   mag,
   input  wire logic [psm_pkg::RANK_W-1:0]  rank,
   output logic [psm_pkg::MAG_W-1:0]        rd_mag,
   output logic                             rd_valid,
   output logic [psm_pkg::SIZE_W-1:0]       size_next
);
   import psm_pkg::*;

   localparam int unsigned FILL_W = $clog2(TOP_COUNT + 1);
   localparam int unsigned CMP_W  = (FILL_W > RANK_W) ? FILL_W : RANK_W;

   logic [MAG_W-1:0]  val_w   [TOP_COUNT+1];
   logic              valid_w [TOP_COUNT+1];
   logic              ge_w    [TOP_COUNT+1];

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [CMP_W-1:0]  fill_wide, fill_next_wide, rank_wide;
   logic [MAG_W-1:0]  mux_mag;

   // virtual head cell: larger than anything, always valid
   assign val_w[0]   = '0;
   assign valid_w[0] = 1'b1;
   assign ge_w[0]    = 1'b1;

   for (genvar i = 0; i < TOP_COUNT; i++) begin : g_cell
      psm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .mag        (mag),
         .left_ge    (ge_w[i]),
         .left_valid (valid_w[i]),
         .left_val   (val_w[i]),
         .val        (val_w[i+1]),
         .valid      (valid_w[i+1]),
         .ge         (ge_w[i+1])
      );
   end

   always_comb begin
      priority if (cmd.clear) begin
         fill_in = '0;
      end else if (cmd.insert && (fill_ff < FILL_W'(TOP_COUNT))) begin
         fill_in = fill_ff + FILL_W'(1);
      end else begin
         fill_in = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign fill_wide      = CMP_W'(fill_ff);
   assign fill_next_wide = CMP_W'(fill_in);
   assign rank_wide      = CMP_W'(rank);
   assign size_next      = fill_next_wide[SIZE_W-1:0];
   assign rd_valid       = rank_wide < fill_wide;

   always_comb begin
      mux_mag = '0;
      for (int i = 0; i < TOP_COUNT; i++) begin
         mux_mag = mux_mag | ((rank_wide == CMP_W'(i)) ? val_w[i+1] : '0);
      end
   end

   assign rd_mag = rd_valid ? mux_mag : '0;

   chk_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(TOP_COUNT))
      else $error("list fill beyond capacity");

   chk_head_valid : assert property (@(posedge clock) disable iff (reset)
      valid_w[1] == (fill_ff != '0))
      else $error("head cell valid disagrees with fill");
endmodule
`default_nettype wire

/* src/psm_power.sv */
// Power pipeline: magnitude and square, then cube and fourth power.
// Depends on psm_pkg.
`default_nettype none
module psm_power (
   input  wire logic                              clock,
   input  wire logic                              load,
   input  wire logic signed [psm_pkg::VAL_W-1:0]  value,
   output logic [psm_pkg::MAG_W-1:0]              mag,
   output logic [psm_pkg::SQ_W-1:0]               sq,
   output logic [psm_pkg::CUBE_W-1:0]             cube,
   output logic [psm_pkg::QUAD_W-1:0]             quad
);
   import psm_pkg::*;

   logic [VAL_W:0]   ext;
   logic [VAL_W:0]   abs_val;
   logic [MAG_W-1:0] mag_in, mag_ff;
   logic [SQ_W-1:0]  sq_in, sq_ff;
   logic [CUBE_W-1:0] cube_in, cube_ff;
   logic [QUAD_W-1:0] quad_in, quad_ff;

   assign ext     = {value[VAL_W-1], value};
   assign abs_val = value[VAL_W-1] ? (~ext + (VAL_W+1)'(1)) : ext;
   assign mag_in  = abs_val[MAG_W-1:0];
   assign sq_in   = SQ_W'(mag_in) * SQ_W'(mag_in);

   always_ff @(posedge clock) begin
      if (load) begin
         mag_ff <= mag_in;
         sq_ff  <= sq_in;
      end
   end

   assign cube_in = CUBE_W'(sq_ff) * CUBE_W'(mag_ff);
   assign quad_in = QUAD_W'(sq_ff) * QUAD_W'(sq_ff);

   always_ff @(posedge clock) begin
      cube_ff <= cube_in;
      quad_ff <= quad_in;
   end

   assign mag  = mag_ff;
   assign sq   = sq_ff;
   assign cube = cube_ff;
   assign quad = quad_ff;
endmodule
`default_nettype wire

/* tb/power_sum_moments_with_top_k_core_tb.sv */
// Self-checking testbench for power_sum_moments_with_top_k_core: running power sums,
// nonzero count, peak magnitude and the ranked top-k magnitude list.
// Depends on psm_pkg and the core RTL; predicts every response and compares it field by field.
`timescale 1ns / 100ps

module power_sum_moments_with_top_k_core_tb;
   import psm_pkg::*;

   localparam int          TOP_N         = TOP_COUNT_DEF;
   localparam logic [1:0]  FUNC_SPARE    = 2'd3;
   localparam int          LIST_RUN      = TOP_N + 40;
   localparam int          MIX_ITEMS     = 270;
   localparam int          STALL_LIMIT   = 2000;
   localparam int          HOLD_CYCLES   = 300;
   localparam int          ERR_PRINT_MAX = 200;
   localparam longint      S48_MAX       = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint      S48_MIN       = -S48_MAX - 1;

   typedef struct packed {
      logic [31:0] count;
      logic [47:0] sum1;
      logic [63:0] sum2;
      logic [63:0] sum3;
      logic [63:0] sum4;
      logic [15:0] peak;
      logic [15:0] ranked;
      logic        rvalid;
      logic [7:0]  size;
      logic        sat;
   } stats_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_func = 2'd0;
   logic signed [15:0] req_value = 16'sd0;
   logic [7:0]         req_rank = 8'd0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [31:0]        rsp_nonzero_count;
   logic signed [47:0] rsp_sum_first;
   logic [63:0]        rsp_sum_second;
   logic signed [63:0] rsp_sum_third;
   logic [63:0]        rsp_sum_fourth;
   logic [15:0]        rsp_max_magnitude;
   logic [15:0]        rsp_ranked_magnitude;
   logic               rsp_rank_valid;
   logic [7:0]         rsp_list_size;
   logic               rsp_saturated;

   // predicted block state
   logic [31:0]        nz_count;
   longint             acc_sum1;
   logic [63:0]        acc_sum2;
   longint             acc_sum3;
   logic [63:0]        acc_sum4;
   int unsigned        peak_mag;
   int unsigned        top_mags[$];
   bit                 sat_seen;

   stats_type          pending_stats[$];
   int                 send_idle_pct = 0;
   int                 rcv_idle_pct = 0;
   bit                 rsp_hold = 1'b0;
   int                 n_errors = 0;
   int                 n_checked = 0;
   int                 n_samples = 0;
   int                 n_reads = 0;
   int                 n_clears = 0;
   int                 n_spare = 0;
   int                 n_sat_rsp = 0;
   int                 fill_max = 0;
   int                 stall_cycles = 0;

   power_sum_moments_with_top_k_core u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_func             (req_func),
      .req_value            (req_value),
      .req_rank             (req_rank),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_nonzero_count    (rsp_nonzero_count),
      .rsp_sum_first        (rsp_sum_first),
      .rsp_sum_second       (rsp_sum_second),
      .rsp_sum_third        (rsp_sum_third),
      .rsp_sum_fourth       (rsp_sum_fourth),
      .rsp_max_magnitude    (rsp_max_magnitude),
      .rsp_ranked_magnitude (rsp_ranked_magnitude),
      .rsp_rank_valid       (rsp_rank_valid),
      .rsp_list_size        (rsp_list_size),
      .rsp_saturated        (rsp_saturated)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void clear_stats();
      nz_count = '0;
      acc_sum1 = 0;
      acc_sum2 = '0;
      acc_sum3 = 0;
      acc_sum4 = '0;
      peak_mag = 0;
      top_mags.delete();
      sat_seen = 1'b0;
   endfunction

   function automatic void accumulate_sample(input logic signed [15:0] sample);
      longint      v;
      longint      mag;
      longint      cube;
      logic [63:0] sq;
      logic [63:0] quad;
      logic [64:0] wide;
      int          pos;
      v    = longint'(sample);
      mag  = (v < 0) ? -v : v;
      sq   = 64'(mag * mag);
      quad = sq * sq;
      cube = v * v * v;
      if (v != 0) begin
         if (nz_count == 32'hFFFF_FFFF) sat_seen = 1'b1;
         else nz_count = nz_count + 1;
      end
      acc_sum1 = acc_sum1 + v;
      if (acc_sum1 > S48_MAX) begin
         acc_sum1 = S48_MAX;
         sat_seen = 1'b1;
      end
      if (acc_sum1 < S48_MIN) begin
         acc_sum1 = S48_MIN;
         sat_seen = 1'b1;
      end
      wide = {1'b0, acc_sum2} + {1'b0, sq};
      if (wide[64]) begin
         acc_sum2 = '1;
         sat_seen = 1'b1;
      end else acc_sum2 = wide[63:0];
      wide = {acc_sum3[63], acc_sum3} + {cube[63], cube};
      if (wide[64] != wide[63]) begin
         acc_sum3 = wide[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
         sat_seen = 1'b1;
      end else acc_sum3 = wide[63:0];
      wide = {1'b0, acc_sum4} + {1'b0, quad};
      if (wide[64]) begin
         acc_sum4 = '1;
         sat_seen = 1'b1;
      end else acc_sum4 = wide[63:0];
      if (mag > peak_mag) peak_mag = mag;
      if (mag != 0) begin
         pos = 0;
         while (pos < top_mags.size() && top_mags[pos] > mag) pos++;
         if (pos < TOP_N) begin
            top_mags.insert(pos, mag);
            if (top_mags.size() > TOP_N) top_mags.delete(TOP_N);
         end
      end
   endfunction

   function automatic stats_type advance_stats(input logic [1:0] func,
                                               input logic signed [15:0] sample,
                                               input logic [7:0] rank);
      stats_type s;
      s.ranked = '0;
      s.rvalid = 1'b0;
      if (func == FUNC_ADD) begin
         accumulate_sample(sample);
         n_samples++;
      end else if (func == FUNC_READ) begin
         n_reads++;
         if (rank < top_mags.size()) begin
            s.rvalid = 1'b1;
            s.ranked = top_mags[rank][15:0];
         end
      end else if (func == FUNC_CLEAR) begin
         clear_stats();
         n_clears++;
      end else n_spare++;
      s.count = nz_count;
      s.sum1  = acc_sum1[47:0];
      s.sum2  = acc_sum2;
      s.sum3  = acc_sum3;
      s.sum4  = acc_sum4;
      s.peak  = peak_mag[15:0];
      s.size  = 8'(top_mags.size());
      s.sat   = sat_seen;
      if (sat_seen) n_sat_rsp++;
      if (top_mags.size() > fill_max) fill_max = top_mags.size();
      return s;
   endfunction

   task automatic send_request(input logic [1:0] func, input logic signed [15:0] sample,
                               input logic [7:0] rank);
      int gap;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= func;
      req_value <= sample;
      req_rank  <= rank;
      do @(posedge clock); while (req_ready !== 1'b1);
      pending_stats.push_back(advance_stats(func, sample, rank));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_stats.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(9))
         0, 1, 2: return 16'($urandom);
         3: begin
            case ($urandom_range(5))
               0: return -16'sd32768;
               1: return -16'sd32767;
               2: return 16'sd32767;
               3: return 16'sd0;
               4: return 16'sd1;
               default: return -16'sd1;
            endcase
         end
         8, 9: return 16'($urandom_range(16000) - 8000);
         default: return 16'($urandom_range(600) - 300);
      endcase
   endfunction

   function automatic logic [7:0] pick_rank();
      int fill;
      int r;
      fill = top_mags.size();
      r = $urandom_range(9);
      if (r < 5 && fill > 0) return 8'($urandom_range(fill - 1));
      if (r < 7) begin
         r = fill - 2 + $urandom_range(4);
         if (r < 0) r = 0;
         if (r > 255) r = 255;
         return 8'(r);
      end
      return 8'($urandom_range(255));
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         n_errors++;
         if (n_errors <= ERR_PRINT_MAX)
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   // response checker
   always @(posedge clock) begin : rsp_monitor
      stats_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_stats.size() == 0) begin
            n_errors++;
            $display("%0t ns: response with no request outstanding", $time);
         end else begin
            want = pending_stats.pop_front();
            check_field("nonzero_count", want.count, rsp_nonzero_count);
            check_field("sum_first", want.sum1, {16'h0, rsp_sum_first});
            check_field("sum_second", want.sum2, rsp_sum_second);
            check_field("sum_third", want.sum3, rsp_sum_third);
            check_field("sum_fourth", want.sum4, rsp_sum_fourth);
            check_field("max_magnitude", want.peak, rsp_max_magnitude);
            check_field("ranked_magnitude", want.ranked, rsp_ranked_magnitude);
            check_field("rank_valid", want.rvalid, rsp_rank_valid);
            check_field("list_size", want.size, rsp_list_size);
            check_field("saturated", want.sat, rsp_saturated);
            n_checked++;
         end
      end
   end

   always @(negedge clock)
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= rcv_idle_pct);

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t ns: no handshake for %0d cycles", $time, stall_cycles);
         $display("== FAIL ==");
         $finish;
      end else stall_cycles <= stall_cycles + 1;
   end

   task automatic test_directed();
      send_request(FUNC_ADD, 16'sd0, 8'd0);
      send_request(FUNC_ADD, 16'sd1, 8'hFF);
      send_request(FUNC_ADD, -16'sd1, 8'd0);
      send_request(FUNC_ADD, 16'sd32767, 8'd0);
      send_request(FUNC_ADD, -16'sd32768, 8'd0);
      send_request(FUNC_ADD, 16'sd5, 8'd0);
      send_request(FUNC_ADD, -16'sd5, 8'd0);
      send_request(FUNC_READ, -16'sd32768, 8'd0);
      send_request(FUNC_READ, 16'sd0, 8'd1);
      send_request(FUNC_READ, 16'sd0, 8'd3);
      send_request(FUNC_READ, 16'sd0, 8'd5);
      send_request(FUNC_READ, 16'sd0, 8'd6);
      send_request(FUNC_READ, 16'sd0, 8'd255);
      send_request(FUNC_SPARE, -16'sd1, 8'd0);
      send_request(FUNC_CLEAR, 16'sd7, 8'd2);
      send_request(FUNC_READ, 16'sd0, 8'd0);
      send_request(FUNC_ADD, -16'sd32768, 8'd0);
      send_request(FUNC_READ, 16'sd0, 8'd0);
   endtask

   // receiver held off while requests keep coming, so the core backs up
   task automatic test_output_stall();
      fork
         begin
            rsp_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold = 1'b0;
         end
         repeat (40) send_request(FUNC_ADD, pick_sample(), 8'($urandom));
      join
   endtask

   task automatic test_random_mix(input int n_items);
      int sent;
      int run_len;
      int pick;
      sent = 0;
      while (sent < n_items) begin
         run_len = $urandom_range(200, 420);
         for (int k = 0; k < run_len && sent < n_items; k++) begin
            pick = $urandom_range(99);
            if (pick < 62) send_request(FUNC_ADD, pick_sample(), 8'($urandom));
            else if (pick < 95) send_request(FUNC_READ, 16'($urandom), pick_rank());
            else send_request(FUNC_SPARE, 16'($urandom), 8'($urandom));
            sent++;
         end
         if (sent < n_items) begin
            send_request(FUNC_CLEAR, 16'($urandom), 8'($urandom));
            sent++;
         end
      end
   endtask

   // more nonzero samples than the list holds, so the smallest entries drop off
   task automatic test_list_overflow();
      logic signed [15:0] sample;
      send_request(FUNC_CLEAR, 16'sd0, 8'd0);
      repeat (LIST_RUN) begin
         sample = 16'($urandom_range(32767, 1));
         if ($urandom_range(1) != 0) sample = -sample;
         send_request(FUNC_ADD, sample, 8'd0);
      end
      send_request(FUNC_ADD, 16'sd1, 8'd0);
      send_request(FUNC_ADD, -16'sd32768, 8'd0);
      send_request(FUNC_READ, 16'sd0, 8'd0);
      send_request(FUNC_READ, 16'sd0, 8'(TOP_N - 1));
      send_request(FUNC_READ, 16'sd0, 8'(TOP_N));
      send_request(FUNC_CLEAR, 16'sd0, 8'd0);
   endtask

   initial begin
      clear_stats();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 36;
      rcv_idle_pct  = 55;
      test_directed();
      wait_drained();
      test_output_stall();
      wait_drained();
      test_random_mix(MIX_ITEMS);
      wait_drained();

      send_idle_pct = 55;
      rcv_idle_pct  = 36;
      test_random_mix(MIX_ITEMS);
      wait_drained();

      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      test_random_mix(MIX_ITEMS);
      wait_drained();
      test_list_overflow();
      wait_drained();

      $display("Checked %0d responses: %0d samples, %0d rank reads, %0d clears, %0d spare.",
               n_checked, n_samples, n_reads, n_clears, n_spare);
      $display("Ranked list reached %0d entries; saturated flag expected in %0d responses.",
               fill_max, n_sat_rsp);
      if (n_errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", n_errors);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
